### hdl/additive_sine_oscillator_bank_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the additive sine oscillator bank
// Short forms for clocked checks, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef ADDITIVE_SINE_OSCILLATOR_BANK_ASSERT_SVH
`define ADDITIVE_SINE_OSCILLATOR_BANK_ASSERT_SVH

// Same-cycle implication.
`define ASOB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASOB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/asob_pkg.sv
// ----------------------------------------------------------------------------
// asob_pkg
// Shared types, widths and codes of the additive sine oscillator bank.
// ----------------------------------------------------------------------------
package asob_pkg;

  // Default sizing of the bank.
  localparam int DEF_MAX_HARMONICS = 64;
  localparam int DEF_TABLE_SIZE    = 1024;

  // Field widths.
  localparam int OP_W     = 2;
  localparam int SLOT_W   = 6;
  localparam int FREQ_W   = 32;
  localparam int AMP_W    = 16;
  localparam int COUNT_W  = 32;
  localparam int SINE_W   = 16;
  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 32;
  localparam int ACTIVE_W = 7;
  localparam int GAIN_W   = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 1'b1;
  localparam logic [GAIN_W-1:0]    DEF_GAIN   = 16'd6554;

  // Request opcodes.
  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_LOAD  = 2'd1,
    OP_GEN   = 2'd2
  } op_e;

  // One entry of the harmonic store.
  typedef struct packed {
    logic [FREQ_W-1:0] freq_word;
    logic [AMP_W-1:0]  amplitude;
  } asob_harm_t;

  // Control from the sequencer to the voice pipeline.
  typedef struct packed {
    logic issue;
    logic acc_clr;
  } asob_pipe_ctrl_t;

endpackage

### hdl/asob_if.sv
// ----------------------------------------------------------------------------
// asob_in_if / asob_out_if
// Valid/ready channels carrying requests into the bank and samples out.
// ----------------------------------------------------------------------------
interface asob_in_if import asob_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [SLOT_W-1:0]   slot;
  logic [FREQ_W-1:0]   freq_word;
  logic [AMP_W-1:0]    amplitude;
  logic [COUNT_W-1:0]  start_count;

  modport source (output valid, op, slot, freq_word, amplitude, start_count, input ready);
  modport sink   (input valid, op, slot, freq_word, amplitude, start_count, output ready);
endinterface

interface asob_out_if import asob_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       clipped;

  modport source (output valid, sample, clipped, input ready);
  modport sink   (input valid, sample, clipped, output ready);
endinterface

### hdl/asob_harm_mem.sv
// ----------------------------------------------------------------------------
// asob_harm_mem
// Harmonic store: tuning word and amplitude per slot, one write and one
// registered read port.
// ----------------------------------------------------------------------------
module asob_harm_mem import asob_pkg::*; #(
  parameter int MaxHarmonics = DEF_MAX_HARMONICS,
  localparam int SlotAw = (MaxHarmonics > 1) ? $clog2(MaxHarmonics) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [SlotAw-1:0] waddr_i,
  input  asob_harm_t        wdata_i,
  input  logic [SlotAw-1:0] raddr_i,
  output asob_harm_t        rdata_o
);

  asob_harm_t mem_q [MaxHarmonics];
  asob_harm_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/asob_sine_rom.sv
// ----------------------------------------------------------------------------
// asob_sine_rom
// Full-scale signed sine table with a registered read port.
// ----------------------------------------------------------------------------
module asob_sine_rom import asob_pkg::*; #(
  parameter int TableSize = DEF_TABLE_SIZE,
  localparam int IdxW = $clog2(TableSize)
) (
  input  logic                     clk_i,
  input  logic [IdxW-1:0]          addr_i,
  output logic signed [SINE_W-1:0] data_o
);

  localparam longint Q30_ONE = 64'sd1073741824;

  // sin(pi/2 * t) for t in Q30, from an odd degree-9 polynomial, as 0..32767.
  function automatic longint quarter_sine(input longint t);
    longint t2;
    longint p;
    longint s;
    longint r;
    t2 = (t * t) / Q30_ONE;
    p  = 64'sd172273;
    p  = -64'sd5026994 + (p * t2) / Q30_ONE;
    p  = 64'sd85569306 + (p * t2) / Q30_ONE;
    p  = -64'sd693598669 + (p * t2) / Q30_ONE;
    p  = 64'sd1686629713 + (p * t2) / Q30_ONE;
    s  = (p * t) / Q30_ONE;
    r  = (s * 64'sd32767 + (Q30_ONE / 2)) / Q30_ONE;
    if (r < 0) begin
      r = 0;
    end
    if (r > 64'sd32767) begin
      r = 64'sd32767;
    end
    return r;
  endfunction

  // Table entry k, folded onto the first quarter wave.
  function automatic logic signed [SINE_W-1:0] sine_entry(input longint k);
    longint four;
    longint q;
    longint rem;
    longint num;
    longint t;
    longint v;
    four = 4 * k;
    q    = four / TableSize;
    rem  = four - q * TableSize;
    num  = q[0] ? (TableSize - rem) : rem;
    t    = (num <<< 30) / TableSize;
    v    = quarter_sine(t);
    if (q >= 2) begin
      v = -v;
    end
    return v[SINE_W-1:0];
  endfunction

  logic signed [SINE_W-1:0] rom_mem [TableSize];
  logic signed [SINE_W-1:0] data_q;

  // Fixed contents, settled at elaboration.
  always_comb begin
    for (int k = 0; k < TableSize; k++) begin
      rom_mem[k] = sine_entry(longint'(k));
    end
  end

  // Registered read.
  always_ff @(posedge clk_i) begin
    data_q <= rom_mem[addr_i];
  end

  assign data_o = data_q;

endmodule

### hdl/asob_voice_pipe.sv
// ----------------------------------------------------------------------------
// asob_voice_pipe
// Per-slot datapath: phase, table index, sine lookup, amplitude product and
// the running sum over the active slots.
// ----------------------------------------------------------------------------
module asob_voice_pipe import asob_pkg::*; #(
  parameter int TableSize    = DEF_TABLE_SIZE,
  parameter int MaxHarmonics = DEF_MAX_HARMONICS,
  localparam int AccW = PROD_W + $clog2(MaxHarmonics) + 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  asob_pipe_ctrl_t        ctrl_i,
  input  asob_harm_t             harm_i,
  input  logic [COUNT_W-1:0]     count_i,
  output logic signed [AccW-1:0] acc_o,
  output logic                   busy_o
);

  localparam int IdxW    = $clog2(TableSize);
  localparam int IdxMulW = FREQ_W + IdxW + 1;

  logic                     v1_q, va_q, vb_q, vc_q, vd_q;
  logic [FREQ_W-1:0]        phase_d, phase_q;
  logic [AMP_W-1:0]         ampa_q, ampb_q, ampc_q;
  logic [IdxMulW-1:0]       idx_full;
  logic [IdxW-1:0]          idx_q;
  logic signed [SINE_W-1:0] sine;
  logic signed [AMP_W:0]    amp_s;
  logic signed [AMP_W+SINE_W:0] prod_full;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [AccW-1:0]   acc_q;

  // Stage valids follow each issued slot through the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.issue;
      va_q <= v1_q;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  // Phase is tuning word times sample counter, modulo 2^32.
  assign phase_d = harm_i.freq_word * count_i;

  // Table index is the phase scaled to the table size.
  assign idx_full = IdxMulW'(phase_q) * IdxMulW'(TableSize);

  always_ff @(posedge clk_i) begin
    phase_q <= phase_d;
    ampa_q  <= harm_i.amplitude;
    idx_q   <= idx_full[FREQ_W +: IdxW];
    ampb_q  <= ampa_q;
    ampc_q  <= ampb_q;
    prod_q  <= prod_full[PROD_W-1:0];
  end

  asob_sine_rom #(
    .TableSize(TableSize)
  ) u_rom (
    .clk_i (clk_i),
    .addr_i(idx_q),
    .data_o(sine)
  );

  // Amplitude times sine entry; the magnitude stays below 2^31.
  assign amp_s     = $signed({1'b0, ampc_q});
  assign prod_full = amp_s * sine;

  // Running sum, cleared when a new sample starts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_clr) begin
      acc_q <= '0;
    end else if (vd_q) begin
      acc_q <= acc_q + {{(AccW-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = v1_q | va_q | vb_q | vc_q | vd_q;

endmodule

### hdl/additive_sine_oscillator_bank.sv
// ----------------------------------------------------------------------------
// additive_sine_oscillator_bank
// Additive synthesiser: sums amplitude-weighted sine lookups over a bank of
// harmonic slots and gives one saturated signed sample per generate request.
// ----------------------------------------------------------------------------
// Usage
//   in_if carries requests: op 0 writes a harmonic slot (tuning word and
//   amplitude), op 1 loads the sample counter, op 2 generates one sample;
//   op 3 is dropped. Ops 0, 1 and 3 give no result.
//   out_if carries one sample and its clip flag for each generate request.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write active_harmonics (0) and
//   out_gain (1); write them only while the bank is idle.
// Timing
//   A generate request reads its active slots, one slot per cycle, from
//   the harmonic store's single read port and streams them through the
//   shared phase, lookup and multiply-add pipeline, followed by drain and a
//   two-step gain multiply. The input is held off while a sample is built.
// Reset
//   Counter and active slot count clear, gain returns to one tenth.
//   The harmonic store is not cleared: write every active slot first.
// Stall
//   A finished sample waits in the output register; slot writes and counter
//   loads are still taken, but the next sample holds until it is taken.
// ----------------------------------------------------------------------------
`include "additive_sine_oscillator_bank_assert.svh"

module additive_sine_oscillator_bank import asob_pkg::*; #(
  parameter int MaxHarmonics = DEF_MAX_HARMONICS,
  parameter int TableSize    = DEF_TABLE_SIZE
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  asob_in_if.sink               in_if,
  asob_out_if.source            out_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int SlotAw = (MaxHarmonics > 1) ? $clog2(MaxHarmonics) : 1;
  localparam int CntW   = $clog2(MaxHarmonics + 1);
  localparam int AccW   = PROD_W + $clog2(MaxHarmonics) + 1;
  localparam int LoW    = 24;
  localparam int HiW    = AccW - LoW;
  localparam int SumW   = AccW + GAIN_W;
  localparam int ScW    = SumW - 32;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_RUN    = 7'b0000010,
    ST_DRAIN  = 7'b0000100,
    ST_MUL_LO = 7'b0001000,
    ST_MUL_HI = 7'b0010000,
    ST_SUM    = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [ACTIVE_W-1:0]  active_q;
  logic [GAIN_W-1:0]    gain_q;
  logic [COUNT_W-1:0]   counter_q;
  logic [CntW-1:0]      rd_idx_q, num_q;
  logic [9:0]           act_ext, act_lim;
  logic                 in_take, gen_take, slot_ok, mem_we;
  asob_harm_t           wdata, rdata;
  asob_pipe_ctrl_t      pipe_ctrl;
  logic signed [AccW-1:0] acc;
  logic                 pipe_busy;
  logic                 neg_q;
  logic [AccW-1:0]      mag_q;
  logic [LoW+GAIN_W-1:0] lo_q;
  logic [HiW+GAIN_W-1:0] hi_q;
  logic [SumW-1:0]      sum;
  logic [ScW-1:0]       scaled_q;
  logic                 out_load, out_valid_q, out_clip_q, sat_clip;
  logic signed [SAMPLE_W-1:0] out_sample_q, sat_sample;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      gain_q   <= DEF_GAIN;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACTIVE: active_q <= cfg_wdata_i[ACTIVE_W-1:0];
        CFG_GAIN:   gain_q   <= cfg_wdata_i[GAIN_W-1:0];
        default:    ;
      endcase
    end
  end

  // Request acceptance and decode.
  assign in_if.ready = (state_q == ST_IDLE);
  assign in_take     = in_if.valid && in_if.ready;
  assign gen_take    = in_take && (in_if.op == OP_GEN);
  assign slot_ok     = 10'(in_if.slot) < 10'(MaxHarmonics);
  assign mem_we      = in_take && (in_if.op == OP_WRITE) && slot_ok;

  // Active slot count, limited to the bank size.
  assign act_ext = 10'(active_q);
  assign act_lim = (act_ext > 10'(MaxHarmonics)) ? 10'(MaxHarmonics) : act_ext;

  assign wdata.freq_word = in_if.freq_word;
  assign wdata.amplitude = in_if.amplitude;

  asob_harm_mem #(
    .MaxHarmonics(MaxHarmonics)
  ) u_harm_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(SlotAw'(in_if.slot)),
    .wdata_i(wdata),
    .raddr_i(rd_idx_q[SlotAw-1:0]),
    .rdata_o(rdata)
  );

  // Pipeline control: clear the sum at the request, then one slot per cycle.
  assign pipe_ctrl.acc_clr = gen_take;
  assign pipe_ctrl.issue   = (state_q == ST_RUN) && (rd_idx_q != num_q);

  asob_voice_pipe #(
    .TableSize   (TableSize),
    .MaxHarmonics(MaxHarmonics)
  ) u_voice_pipe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (pipe_ctrl),
    .harm_i (rdata),
    .count_i(counter_q),
    .acc_o  (acc),
    .busy_o (pipe_busy)
  );

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_if.ready);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (gen_take) state_d = ST_RUN;
      ST_RUN:    if (!pipe_ctrl.issue) state_d = ST_DRAIN;
      ST_DRAIN:  if (!pipe_busy) state_d = ST_MUL_LO;
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_SUM;
      ST_SUM:    state_d = ST_OUT;
      ST_OUT:    if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer state, slot index and sample counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_idx_q  <= '0;
      num_q     <= '0;
      counter_q <= '0;
    end else begin
      state_q <= state_d;
      if (gen_take) begin
        rd_idx_q <= '0;
        num_q    <= CntW'(act_lim);
      end else if (pipe_ctrl.issue) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (in_take && (in_if.op == OP_LOAD)) begin
        counter_q <= in_if.start_count;
      end else if (out_load) begin
        counter_q <= counter_q + 1'b1;
      end
    end
  end

  // Gain scaling on the magnitude, in two partial products.
  assign sum = (SumW'(hi_q) << LoW) + SumW'(lo_q);

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DRAIN) && !pipe_busy) begin
      neg_q <= acc[AccW-1];
      mag_q <= acc[AccW-1] ? AccW'(-acc) : AccW'(acc);
    end
    if (state_q == ST_MUL_LO) begin
      lo_q <= mag_q[LoW-1:0] * gain_q;
    end
    if (state_q == ST_MUL_HI) begin
      hi_q <= mag_q[AccW-1:LoW] * gain_q;
    end
    if (state_q == ST_SUM) begin
      scaled_q <= sum[SumW-1:32];
    end
  end

  // Saturation to a signed 16-bit sample; truncation is toward zero.
  always_comb begin
    if (neg_q) begin
      sat_clip   = scaled_q > ScW'(32768);
      sat_sample = sat_clip ? 16'sh8000 : -$signed(scaled_q[SAMPLE_W-1:0]);
    end else begin
      sat_clip   = scaled_q > ScW'(32767);
      sat_sample = sat_clip ? 16'sh7fff : $signed(scaled_q[SAMPLE_W-1:0]);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sample_q <= sat_sample;
      out_clip_q   <= sat_clip;
    end
  end

  assign out_if.valid   = out_valid_q;
  assign out_if.sample  = out_sample_q;
  assign out_if.clipped = out_clip_q;

  // Checks on the sequencing and the saturation.
  `ASOB_ASSERT_NEXT(a_gen_holds_input, gen_take, !in_if.ready, "generate did not hold off input")
  `ASOB_ASSERT_IMPL(a_idle_pipe_empty, state_q == ST_IDLE, !pipe_busy, "pipeline busy when idle")
  `ASOB_ASSERT_IMPL(a_clip_at_rail, out_if.valid && out_if.clipped, (out_if.sample == 16'sh7fff) || (out_if.sample == 16'sh8000), "clipped sample not at a rail")

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the additive sine oscillator bank. A short table of
// directed requests covers reset state, counter wrap, the spare opcode and
// both saturation limits. About a thousand random requests follow under a
// series of slot-count and gain settings. Every sample is checked against
// a table value or an in-bench model, with bursty requests and a stalling sink.
// ----------------------------------------------------------------------------
module tb_top;
  import asob_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int TAIL_CYCLES  = 100;
  localparam int ITEM_TARGET  = 1100;
  localparam int LONG_HOLD    = 400;
  localparam int SLOTS        = DEF_MAX_HARMONICS;
  localparam int ROM_DEPTH    = DEF_TABLE_SIZE;
  localparam int IDX_W        = $clog2(ROM_DEPTH);
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam longint Q30_ONE   = 64'sd1073741824;
  localparam longint TWO_POW32 = 64'sd4294967296;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [SLOT_W-1:0]  slot;
    logic [FREQ_W-1:0]  freq_word;
    logic [AMP_W-1:0]   amplitude;
    logic [COUNT_W-1:0] start_count;
  } req_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                clipped;
  } smp_t;

  // One row of the directed table: a register write or a request.
  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    req_t                  req;
    logic                  typed;
    smp_t                  want;
  } row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  asob_in_if  req_ch ();
  asob_out_if smp_ch ();

  additive_sine_oscillator_bank DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (req_ch),
    .out_if      (smp_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Model state of the bank.
  logic [FREQ_W-1:0]   tune_q   [SLOTS];
  logic [AMP_W-1:0]    level_q  [SLOTS];
  logic [COUNT_W-1:0]  count_q;
  logic [ACTIVE_W-1:0] active_q;
  logic [GAIN_W-1:0]   gain_q;
  shortint             sine_tab [ROM_DEPTH];

  smp_t pending_samples [$];

  int useful_items   = 0;
  int spare_items    = 0;
  int samples_seen   = 0;
  int clipped_seen   = 0;
  int settings_used  = 0;
  int mismatches     = 0;
  int burst_left     = 0;
  int cycles         = 0;
  bit long_hold_done = 1'b0;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sum of amplitude-weighted sine lookups over the active slots, scaled and
  // saturated to one signed sample.
  function automatic smp_t synth_sample();
    smp_t              s;
    int                n;
    logic [FREQ_W-1:0] phase;
    longint            acc;
    longint            lvl;
    longint            sine;
    longint            gain;
    longint            value;
    n   = (active_q > SLOTS) ? SLOTS : int'(active_q);
    acc = 0;
    for (int i = 0; i < n; i++) begin
      phase = tune_q[i] * count_q;
      lvl   = longint'(level_q[i]);
      sine  = longint'(sine_tab[phase[FREQ_W-1 -: IDX_W]]);
      acc  += lvl * sine;
    end
    gain      = longint'(gain_q);
    value     = (acc * gain) / TWO_POW32;
    s.clipped = 1'b1;
    if (value > 32767) begin
      value = 32767;
    end else if (value < -32768) begin
      value = -32768;
    end else begin
      s.clipped = 1'b0;
    end
    s.sample = value[SAMPLE_W-1:0];
    return s;
  endfunction

  // Applies one accepted request to the model and queues the sample it owes.
  task automatic model_request(input req_t r, input logic typed, input smp_t want);
    smp_t s;
    case (r.op)
      OP_WRITE: begin
        tune_q[r.slot]  = r.freq_word;
        level_q[r.slot] = r.amplitude;
      end
      OP_LOAD: begin
        count_q = r.start_count;
      end
      OP_GEN: begin
        s = typed ? want : synth_sample();
        pending_samples = {pending_samples, s};
        count_q = count_q + 1'b1;
      end
      default: begin
      end
    endcase
  endtask

  function automatic req_t random_req(input logic [OP_W-1:0] op);
    req_t r;
    r.op          = op;
    r.slot        = SLOT_W'($urandom_range(0, SLOTS - 1));
    r.freq_word   = $urandom;
    r.amplitude   = AMP_W'($urandom_range(0, 65535));
    r.start_count = $urandom;
    return r;
  endfunction

  function automatic row_t req_row(input logic [OP_W-1:0] op, input int slot,
                                   input logic [FREQ_W-1:0] freq,
                                   input logic [AMP_W-1:0] amp,
                                   input logic [COUNT_W-1:0] cnt,
                                   input logic typed = 1'b0,
                                   input logic [SAMPLE_W-1:0] ws = '0,
                                   input logic wc = 1'b0);
    row_t row;
    row                 = '0;
    row.req.op          = op;
    row.req.slot        = slot[SLOT_W-1:0];
    row.req.freq_word   = freq;
    row.req.amplitude   = amp;
    row.req.start_count = cnt;
    row.typed           = typed;
    row.want.sample     = ws;
    row.want.clipped    = wc;
    return row;
  endfunction

  function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
    row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  // Offers one request, in bursts of random length with random gaps between.
  task automatic send_req(input req_t r, input logic typed = 1'b0, input smp_t want = '0);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        req_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    req_ch.valid       = 1'b1;
    req_ch.op          = r.op;
    req_ch.slot        = r.slot;
    req_ch.freq_word   = r.freq_word;
    req_ch.amplitude   = r.amplitude;
    req_ch.start_count = r.start_count;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    model_request(r, typed, want);
    if (r.op == OP_SPARE) spare_items++;
    else useful_items++;
  endtask

  // Stops offering requests and waits for every owed sample to arrive.
  task automatic wait_drained(input logic with_tail);
    @(negedge clk_i);
    req_ch.valid = 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    if (with_tail) repeat (TAIL_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_ACTIVE) active_q = data[ACTIVE_W-1:0];
    else gain_q = data[GAIN_W-1:0];
    settings_used++;
  endtask

  // Sample sink: changes its stall pattern after each random stretch and, once,
  // holds off for a long stretch so that the bank backs up into its input.
  initial begin : sample_sink
    int mode;
    int stretch;
    smp_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!long_hold_done && samples_seen >= 120) begin
        @(negedge clk_i);
        smp_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        long_hold_done = 1'b1;
      end else begin
        mode    = $urandom_range(0, 2);
        stretch = $urandom_range(8, 60);
        repeat (stretch) begin
          @(negedge clk_i);
          case (mode)
            0:       smp_ch.ready = 1'b1;
            1:       smp_ch.ready = 1'($urandom_range(0, 1));
            default: smp_ch.ready = ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  // Sample checker.
  always @(posedge clk_i) begin : sample_check
    smp_t want;
    if (rst_ni && smp_ch.valid === 1'b1 && smp_ch.ready === 1'b1) begin
      samples_seen++;
      if (smp_ch.clipped === 1'b1) clipped_seen++;
      if (pending_samples.size() == 0) begin
        $error("sample %0d arrived with no generate request outstanding",
               $signed(smp_ch.sample));
        mismatches++;
      end else begin
        want = pending_samples.pop_front();
        if (smp_ch.sample !== want.sample) begin
          $error("sample: expected %0d, got %0d", $signed(want.sample),
                 $signed(smp_ch.sample));
          mismatches++;
        end
        if (smp_ch.clipped !== want.clipped) begin
          $error("clipped: expected %0b, got %0b", want.clipped, smp_ch.clipped);
          mismatches++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("additive_sine_oscillator_bank: mismatch");
      $finish;
    end
  end

  // Stimulus.
  initial begin : stimulus
    row_t                  plan [$];
    req_t                  r;
    int                    quad;
    int                    rem;
    int                    num;
    longint                t;
    longint                t2;
    longint                p;
    longint                s;
    longint                v;
    int                    phase_no;
    int                    phase_end;
    int                    pick;
    int                    run_len;
    logic [ACTIVE_W-1:0]   act;
    logic [GAIN_W-1:0]     gain;
    logic [ACTIVE_W-1:0]   fixed_act  [5];
    logic [GAIN_W-1:0]     fixed_gain [5];

    req_ch.valid       = 1'b0;
    req_ch.op          = OP_WRITE;
    req_ch.slot        = '0;
    req_ch.freq_word   = '0;
    req_ch.amplitude   = '0;
    req_ch.start_count = '0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_ACTIVE;
    cfg_wdata_i        = '0;
    rst_ni             = 1'b0;

    // Model reset state, and the sine table from quarter-wave symmetry and
    // an odd polynomial in Q30.
    active_q = '0;
    gain_q   = DEF_GAIN;
    count_q  = '0;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      quad = (4 * k) / ROM_DEPTH;
      rem  = 4 * k - quad * ROM_DEPTH;
      num  = (quad % 2 == 1) ? ROM_DEPTH - rem : rem;
      t    = (longint'(num) <<< 30) / ROM_DEPTH;
      t2   = (t * t) / Q30_ONE;
      p    = 172273;
      p    = -5026994 + (p * t2) / Q30_ONE;
      p    = 85569306 + (p * t2) / Q30_ONE;
      p    = -693598669 + (p * t2) / Q30_ONE;
      p    = 1686629713 + (p * t2) / Q30_ONE;
      s    = (p * t) / Q30_ONE;
      v    = (s * 32767 + Q30_ONE / 2) / Q30_ONE;
      if (v < 0) v = 0;
      if (v > 32767) v = 32767;
      sine_tab[k] = shortint'((quad >= 2) ? -v : v);
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table. Slots 1 and 2 sit at a quarter turn per sample, so the
    // counter walks them through the peaks and zero crossings of the table.
    plan = {plan, req_row(OP_GEN, 0, '0, '0, '0, 1'b1, 16'sh0000, 1'b0)};
    plan = {plan, req_row(OP_SPARE, 63, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF)};
    plan = {plan, req_row(OP_LOAD, 0, '0, '0, 32'hFFFF_FFFF)};
    plan = {plan, req_row(OP_WRITE, 0, 32'hFFFF_FFFF, 16'h0000, '0)};
    plan = {plan, req_row(OP_WRITE, 1, 32'h4000_0000, 16'hFFFF, '0)};
    plan = {plan, req_row(OP_WRITE, 2, 32'h4000_0000, 16'hFFFF, '0)};
    plan = {plan, cfg_row(CFG_ACTIVE, 16'd1)};
    // Silent slot at the top count, after which the counter wraps to zero.
    plan = {plan, req_row(OP_GEN, 0, '0, '0, '0, 1'b1, 16'sh0000, 1'b0)};
    plan = {plan, cfg_row(CFG_ACTIVE, 16'd3)};
    plan = {plan, req_row(OP_GEN, 0, '0, '0, '0, 1'b1, 16'sh0000, 1'b0)};
    plan = {plan, cfg_row(CFG_GAIN, 16'hFFFF)};
    // Positive peak, zero crossing, negative peak at full gain.
    plan = {plan, req_row(OP_GEN, 0, '0, '0, '0, 1'b1, 16'sh7FFF, 1'b1)};
    plan = {plan, req_row(OP_GEN, 0, '0, '0, '0, 1'b1, 16'sh0000, 1'b0)};
    plan = {plan, req_row(OP_GEN, 0, '0, '0, '0, 1'b1, 16'sh8000, 1'b1)};
    plan = {plan, cfg_row(CFG_GAIN, 16'h0000)};
    plan = {plan, req_row(OP_LOAD, 0, '0, '0, 32'd1)};
    plan = {plan, req_row(OP_GEN, 0, '0, '0, '0, 1'b1, 16'sh0000, 1'b0)};
    plan = {plan, req_row(OP_WRITE, 63, 32'hFFFF_FFFF, 16'hFFFF, '0)};
    plan = {plan, cfg_row(CFG_GAIN, DEF_GAIN)};
    plan = {plan, cfg_row(CFG_ACTIVE, 16'd2)};
    plan = {plan, req_row(OP_LOAD, 0, '0, '0, 32'h1234_5678)};
    plan = {plan, req_row(OP_GEN, 0, '0, '0, '0)};
    plan = {plan, req_row(OP_GEN, 0, '0, '0, '0)};
    plan = {plan, req_row(OP_WRITE, 1, 32'h0AB0_C0D1, 16'h8001, '0)};
    plan = {plan, req_row(OP_GEN, 0, '0, '0, '0)};

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_drained(1'b1);
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_req(plan[i].req, plan[i].typed, plan[i].want);
      end
    end

    // Fill every slot so that any slot count is legal from here on.
    for (int i = 0; i < SLOTS; i++) begin
      r      = random_req(OP_WRITE);
      r.slot = i[SLOT_W-1:0];
      send_req(r);
    end

    // Random phases; the first five use fixed settings that include the extremes of both registers.
    fixed_act  = '{7'd64, 7'd127, 7'd0, 7'd1, 7'd64};
    fixed_gain = '{16'hFFFF, DEF_GAIN, 16'h1234, 16'hFFFF, 16'h0000};
    phase_no   = 0;
    while (useful_items < ITEM_TARGET) begin
      wait_drained(1'b1);
      if (phase_no < 5) begin
        act  = fixed_act[phase_no];
        gain = fixed_gain[phase_no];
      end else begin
        act  = ACTIVE_W'($urandom_range(0, 127));
        gain = GAIN_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 8000));
      end
      write_reg(CFG_ACTIVE, {{(CFG_DATA_W - ACTIVE_W){1'b0}}, act});
      write_reg(CFG_GAIN, gain);
      phase_no++;
      phase_end = useful_items + $urandom_range(50, 90);
      while (useful_items < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          wait_drained(1'b0);
        end else if (pick < 45) begin
          // Counter load followed by a run of samples, sometimes across the wrap.
          r = random_req(OP_LOAD);
          if ($urandom_range(0, 3) == 0) r.start_count = 32'hFFFF_FFFF - $urandom_range(0, 4);
          send_req(r);
          run_len = $urandom_range(1, 8);
          repeat (run_len) send_req(random_req(OP_GEN));
        end else if (pick < 70) begin
          send_req(random_req(OP_WRITE));
          send_req(random_req(OP_GEN));
        end else if (pick < 92) begin
          send_req(random_req(OP_GEN));
        end else begin
          send_req(random_req(OP_SPARE));
        end
      end
    end

    wait_drained(1'b1);
    $display("Summary: %0d requests plus %0d spare opcodes, %0d samples checked, %0d clipped.",
             useful_items, spare_items, samples_seen, clipped_seen);
    $display("Summary: %0d register writes, %0d random slot-count and gain settings.",
             settings_used, phase_no);
    if (mismatches == 0) begin
      $display("additive_sine_oscillator_bank: match");
    end else begin
      $display("additive_sine_oscillator_bank: mismatch");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/asob_pkg.sv
hdl/asob_if.sv
hdl/asob_harm_mem.sv
hdl/asob_sine_rom.sv
hdl/asob_voice_pipe.sv
hdl/additive_sine_oscillator_bank.sv
tb/tb_top.sv
